// ===== rtl/ipfk_pkg.sv =====
// Shared types and constants for the IP flow key extractor.
package ipfk_pkg;
  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_V4        = 3'd1;
  localparam logic [2:0] PH_V6        = 3'd2;
  localparam logic [2:0] PH_EXT_NEXT  = 3'd3;
  localparam logic [2:0] PH_EXT_LEN   = 3'd4;
  localparam logic [2:0] PH_EXT_BODY  = 3'd5;
  localparam logic [2:0] PH_TRANSPORT = 3'd6;
  localparam logic [2:0] PH_DRAIN     = 3'd7;

  localparam logic [7:0] PROTO_TCP    = 8'd6;
  localparam logic [7:0] PROTO_UDP    = 8'd17;
  localparam logic [7:0] EXT_HOP_OPTS = 8'd0;
  localparam logic [7:0] EXT_ROUTE    = 8'd43;
  localparam logic [7:0] EXT_DST_OPTS = 8'd60;
  localparam logic [7:0] EXT_FRAG     = 8'd44;
  localparam logic [7:0] EXT_AUTH_HDR = 8'd51;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TRUNC = 2'd1;
  localparam logic [1:0] ST_BADV  = 2'd2;
  localparam logic [1:0] ST_PROTO = 2'd3;

  localparam logic [2:0] CS_UNKNOWN = 3'd0;
  localparam logic [2:0] CS_SYN_SENT = 3'd1;
  localparam logic [2:0] CS_SYN_RCVD = 3'd2;
  localparam logic [2:0] CS_ESTAB = 3'd3;
  localparam logic [2:0] CS_FIN_WAIT = 3'd4;
  localparam logic [2:0] CS_CLOSED = 3'd5;
  localparam logic [2:0] CS_UDP = 3'd6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       arrived_inbound;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] low_addr;
    logic [31:0] high_addr;
    logic [15:0] low_port;
    logic [15:0] high_port;
    logic [7:0]  protocol_number;
    logic [2:0]  conn_state;
    logic        direction_inbound;
    logic [15:0] packet_bytes;
  } out_word_t;

  // Raw packet summary passed from parser to key builder.
  typedef struct packed {
    logic        ver_ok;
    logic        in_transport;
    logic [7:0]  nh;
    logic [15:0] hoff;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  flags;
    logic        inbound;
    logic [15:0] bytes;
  } summary_t;

  function automatic logic is_ext(input logic [7:0] c);
    return c == EXT_HOP_OPTS || c == EXT_ROUTE || c == EXT_DST_OPTS ||
           c == EXT_FRAG || c == EXT_AUTH_HDR;
  endfunction

  function automatic logic [2:0] tcp_state(input logic [7:0] f, input logic inb);
    priority if (f[2]) return CS_CLOSED;
    else if (f[0]) return CS_FIN_WAIT;
    else if (f[1] && f[4]) return CS_SYN_RCVD;
    else if (f[1]) return inb ? CS_SYN_RCVD : CS_SYN_SENT;
    else if (f[4]) return CS_ESTAB;
    else return CS_UNKNOWN;
  endfunction
endpackage

// ===== rtl/ipfk_if.sv =====
// Valid/ready channel interfaces for input bytes and result words.
interface ipfk_in_if;
  import ipfk_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ipfk_out_if;
  import ipfk_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/ipfk_parser.sv =====
// Front end: per-byte header walk, emits a packet summary on the last byte.
module ipfk_parser
  import ipfk_pkg::*;
#(
  parameter int LENGTH_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     take,
  input  in_word_t word,
  output logic     sum_valid,
  output summary_t sum
);
  localparam logic [LENGTH_BITS-1:0] CMAX = '1;
  localparam int PW = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

  logic [2:0] phase;
  logic [LENGTH_BITS-1:0] cnt;
  logic [3:0] ver;
  logic [31:0] src, dst;
  logic [7:0] nh, elb, flags;
  logic [15:0] hoff, sport, dport;
  logic inb;

  logic [2:0] ph0, ph1;
  logic [LENGTH_BITS-1:0] pos, cnt1;
  logic [3:0] ver0;
  logic [31:0] src0, src1, dst0, dst1;
  logic [7:0] nh0, nh1, elb0, elb1, fl0, fl1, b;
  logic [15:0] ho0, ho1, sp0, sp1, dp0, dp1;
  logic inb0;
  logic [PW-1:0] pos_w, cnt_w;
  logic [11:0] elen;

  assign b = word.data_byte;

  always_comb begin
    ph0 = phase; ver0 = ver; src0 = src; dst0 = dst; nh0 = nh; elb0 = elb;
    ho0 = hoff; sp0 = sport; dp0 = dport; fl0 = flags; inb0 = inb; pos = cnt;
    if (phase == PH_IDLE) begin
      pos = '0; ver0 = b[7:4]; src0 = '0; dst0 = '0; nh0 = '0; elb0 = '0;
      ho0 = '0; sp0 = '0; dp0 = '0; fl0 = '0; inb0 = word.arrived_inbound;
      if (b[7:4] == 4'd4) begin
        ph0 = PH_V4; elb0 = {4'd0, b[3:0]};
      end else if (b[7:4] == 4'd6) ph0 = PH_V6;
      else ph0 = PH_DRAIN;
    end
    cnt1 = (pos != CMAX) ? pos + 1'b1 : pos;
    pos_w = PW'(pos);
    cnt_w = PW'(cnt1);
    ph1 = ph0; src1 = src0; dst1 = dst0; nh1 = nh0; elb1 = elb0;
    ho1 = ho0; sp1 = sp0; dp1 = dp0; fl1 = fl0;
    elen = '0;
    unique case (ph0)
      PH_V4: begin
        if (pos_w == PW'(9)) nh1 = b;
        else if (pos_w >= PW'(12) && pos_w <= PW'(15)) src1 = {src0[23:0], b};
        else if (pos_w >= PW'(16) && pos_w <= PW'(19)) dst1 = {dst0[23:0], b};
        if (elb0 >= 8'd5 && cnt_w == PW'({elb0, 2'b00})) begin
          ph1 = PH_TRANSPORT; ho1 = '0;
        end else if (elb0 < 8'd5 && cnt_w == PW'(20)) ph1 = PH_DRAIN;
      end
      PH_V6: begin
        if (pos_w == PW'(6)) nh1 = b;
        else if (pos_w >= PW'(20) && pos_w <= PW'(23)) src1 = {src0[23:0], b};
        else if (pos_w >= PW'(36) && pos_w <= PW'(39)) dst1 = {dst0[23:0], b};
        if (cnt_w == PW'(40)) begin
          ph1 = is_ext(nh0) ? PH_EXT_NEXT : PH_TRANSPORT; ho1 = '0;
        end
      end
      PH_EXT_NEXT: begin
        elb1 = b; ph1 = PH_EXT_LEN;
      end
      PH_EXT_LEN: begin
        if (nh0 == EXT_FRAG) elen = 12'd8;
        else if (nh0 == EXT_AUTH_HDR) elen = ({4'b0, b} + 12'd2) << 2;
        else elen = ({4'b0, b} + 12'd1) << 3;
        ho1 = 16'(elen - 12'd2); nh1 = elb0; ph1 = PH_EXT_BODY;
      end
      PH_EXT_BODY: begin
        ho1 = (ho0 != 16'd0) ? ho0 - 16'd1 : ho0;
        if (ho1 == 16'd0) begin
          ph1 = is_ext(nh0) ? PH_EXT_NEXT : PH_TRANSPORT;
        end
      end
      PH_TRANSPORT: begin
        if (ho0 <= 16'd1) sp1 = {sp0[7:0], b};
        else if (ho0 <= 16'd3) dp1 = {dp0[7:0], b};
        else if (ho0 == 16'd13) fl1 = b;
        if (ho0 != 16'hFFFF) ho1 = ho0 + 16'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE; cnt <= '0; sum_valid <= 1'b0;
    end else begin
      sum_valid <= take && word.last_byte;
      if (take) begin
        phase <= word.last_byte ? PH_IDLE : ph1;
        cnt <= cnt1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ver <= ver0; src <= src1; dst <= dst1; nh <= nh1; elb <= elb1; hoff <= ho1;
      sport <= sp1; dport <= dp1; flags <= fl1; inb <= inb0;
      sum.ver_ok <= (ver0 == 4'd4) || (ver0 == 4'd6);
      sum.in_transport <= ph1 == PH_TRANSPORT;
      sum.nh <= nh1; sum.hoff <= ho1; sum.src <= src1; sum.dst <= dst1;
      sum.sport <= sp1; sum.dport <= dp1; sum.flags <= fl1; sum.inbound <= inb0;
      sum.bytes <= (cnt_w > PW'(16'hFFFF)) ? 16'hFFFF : cnt_w[15:0];
    end
  end
endmodule

// ===== rtl/ipfk_fifo.sv =====
// Short queue between parser and key builder.
module ipfk_fifo
  import ipfk_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  summary_t din,
  output logic     full,
  output logic     empty,
  input  logic     pop,
  output summary_t dout
);
  summary_t mem [4];
  logic [1:0] wp, rp;
  logic [2:0] n;
  assign full = n[2];
  assign empty = n == 3'd0;
  assign dout = mem[rp];
  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; n <= '0;
    end else begin
      if (push) wp <= wp + 2'd1;
      if (pop) rp <= rp + 2'd1;
      n <= n + {2'b0, push} - {2'b0, pop};
    end
  end
  a_noovf: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue overflow");
  a_nounf: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("queue underflow");
  a_cnt: assert property (@(posedge clk) disable iff (rst) n <= 3'd4)
    else $error("bad count");
endmodule

// ===== rtl/ipfk_keygen.sv =====
// Back end: classifies a packet summary into status, flow key and state.
module ipfk_keygen
  import ipfk_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     sum_valid,
  input  summary_t sum,
  output logic     sum_pop,
  ipfk_out_if.source res
);
  out_word_t w;
  logic tcp, udp;
  always_comb begin
    tcp = sum.nh == PROTO_TCP;
    udp = sum.nh == PROTO_UDP;
    w = '0;
    w.direction_inbound = sum.inbound;
    w.packet_bytes = sum.bytes;
    priority if (!sum.ver_ok) w.status = ST_BADV;
    else if (!sum.in_transport) w.status = ST_TRUNC;
    else if (!tcp && !udp) begin
      w.status = ST_PROTO; w.protocol_number = sum.nh;
    end else if (sum.hoff < (tcp ? 16'd20 : 16'd8)) w.status = ST_TRUNC;
    else begin
      w.status = ST_OK; w.protocol_number = sum.nh;
      w.conn_state = udp ? CS_UDP : tcp_state(sum.flags, sum.inbound);
      if (sum.src > sum.dst) begin
        w.low_addr = sum.dst; w.low_port = sum.dport;
        w.high_addr = sum.src; w.high_port = sum.sport;
      end else begin
        w.low_addr = sum.src; w.low_port = sum.sport;
        w.high_addr = sum.dst; w.high_port = sum.dport;
      end
    end
  end
  assign sum_pop = sum_valid && (!res.valid || res.ready);
  always_ff @(posedge clk) begin
    if (rst) res.valid <= 1'b0;
    else if (!res.valid || res.ready) res.valid <= sum_valid;
  end
  always_ff @(posedge clk) begin
    if (sum_pop) res.data <= w;
  end
endmodule

// ===== rtl/ip_flow_key_extractor.sv =====
// Top level of the IP flow key extractor.
// Usage:
//   in  : one packet byte per word (data_byte, last_byte, arrived_inbound),
//         starting at the IP header; arrived_inbound is sampled on byte one.
//   out : one result word per packet, after the last byte: status, canonical
//         addresses and ports, protocol, connection state, direction, length.
// Throughput: one byte per cycle while in.ready is high, back to back across packets.
// Result path: parser register, queue write, output register.
// The parser updates its header state from each byte; summaries go through
// a four-entry queue to the key builder. in.ready drops when the queue is
// full, or holds three with a fourth on its way, so a stalled receiver backs
// up into the input once five finished packets wait (four queued, one in the
// output register). Reset (rst, synchronous) empties the queue and
// returns the parser to expecting the first byte of a packet.
module ip_flow_key_extractor
  import ipfk_pkg::*;
#(
  parameter int LENGTH_BITS = 16
) (
  input logic clk,
  input logic rst,
  ipfk_in_if.sink in,
  ipfk_out_if.source out
);
  logic take, sv, full, empty, pop, room;
  summary_t s, q;
  logic [2:0] inflight;

  // keep room for a summary still in the parser register
  assign room = !full && !(sv && inflight == 3'd3);
  assign in.ready = room;
  assign take = in.valid && in.ready;

  always_ff @(posedge clk) begin
    if (rst) inflight <= '0;
    else inflight <= inflight + {2'b0, sv} - {2'b0, pop};
  end

  ipfk_parser #(.LENGTH_BITS(LENGTH_BITS)) u_parser (
    .clk, .rst, .take, .word(in.data), .sum_valid(sv), .sum(s)
  );
  ipfk_fifo u_fifo (
    .clk, .rst, .push(sv), .din(s), .full, .empty, .pop, .dout(q)
  );
  ipfk_keygen u_keygen (
    .clk, .rst, .sum_valid(!empty), .sum(q), .sum_pop(pop), .res(out)
  );
endmodule

// ===== tb/ipfk_key_checker.sv =====
// Checker for the IP flow key extractor: predicts flow keys and compares results.
module ipfk_key_checker
  import ipfk_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  ipfk_in_if.sink    in_mon,
  ipfk_out_if.sink   out_mon,
  output int         errors,
  output int         pending,
  output int         keys_seen
);
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  out_word_t   key_queue[$];
  logic [2:0]  phase;
  logic [15:0] nbytes;
  logic [3:0]  ver;
  logic [31:0] src_w, dst_w;
  logic [7:0]  nh, saved;
  logic [15:0] off;
  logic [15:0] sport, dport;
  logic [7:0]  flags;
  logic        inb;

  function automatic logic ext_code(input logic [7:0] c);
    return c == EXT_HOP_OPTS || c == EXT_ROUTE || c == EXT_DST_OPTS ||
           c == EXT_FRAG || c == EXT_AUTH_HDR;
  endfunction

  function automatic logic [2:0] flag_state(input logic [7:0] f, input logic i);
    if (f[2]) return CS_CLOSED;
    if (f[0]) return CS_FIN_WAIT;
    if (f[1] && f[4]) return CS_SYN_RCVD;
    if (f[1]) return i ? CS_SYN_RCVD : CS_SYN_SENT;
    if (f[4]) return CS_ESTAB;
    return CS_UNKNOWN;
  endfunction

  task automatic track_byte(input in_word_t w);
    logic [15:0] pos;
    logic [31:0] len;
    out_word_t   k;
    if (phase == PH_IDLE) begin
      nbytes = 0; src_w = 0; dst_w = 0; nh = 0; off = 0; saved = 0;
      sport = 0; dport = 0; flags = 0;
      inb = w.arrived_inbound;
      ver = w.data_byte[7:4];
      if (ver == 4) begin
        phase = PH_V4;
        saved = {4'd0, w.data_byte[3:0]};
      end else if (ver == 6) begin
        phase = PH_V6;
      end else begin
        phase = PH_DRAIN;
      end
    end
    pos = nbytes;
    if (nbytes < COUNT_MAX) nbytes++;
    case (phase)
      PH_V4: begin
        if (pos == 9) nh = w.data_byte;
        else if (pos >= 12 && pos <= 15) src_w = {src_w[23:0], w.data_byte};
        else if (pos >= 16 && pos <= 19) dst_w = {dst_w[23:0], w.data_byte};
        if (saved >= 5 && nbytes == saved * 4) begin
          phase = PH_TRANSPORT;
          off = 0;
        end else if (saved < 5 && nbytes == 20) begin
          phase = PH_DRAIN;
        end
      end
      PH_V6: begin
        if (pos == 6) nh = w.data_byte;
        else if (pos >= 20 && pos <= 23) src_w = {src_w[23:0], w.data_byte};
        else if (pos >= 36 && pos <= 39) dst_w = {dst_w[23:0], w.data_byte};
        if (nbytes == 40) begin
          phase = ext_code(nh) ? PH_EXT_NEXT : PH_TRANSPORT;
          off = 0;
        end
      end
      PH_EXT_NEXT: begin
        saved = w.data_byte;
        phase = PH_EXT_LEN;
      end
      PH_EXT_LEN: begin
        if (nh == EXT_FRAG) len = 8;
        else if (nh == EXT_AUTH_HDR) len = (w.data_byte + 2) * 4;
        else len = (w.data_byte + 1) * 8;
        off = 16'(len - 2);
        nh = saved;
        phase = PH_EXT_BODY;
      end
      PH_EXT_BODY: begin
        if (off > 0) off--;
        if (off == 0) phase = ext_code(nh) ? PH_EXT_NEXT : PH_TRANSPORT;
      end
      PH_TRANSPORT: begin
        if (off <= 1) sport = {sport[7:0], w.data_byte};
        else if (off <= 3) dport = {dport[7:0], w.data_byte};
        else if (off == 13) flags = w.data_byte;
        if (off < 16'hFFFF) off++;
      end
      default: ;
    endcase
    if (w.last_byte) begin
      k = '0;
      k.direction_inbound = inb;
      k.packet_bytes = nbytes;
      if (ver != 4 && ver != 6) begin
        k.status = ST_BADV;
      end else if (phase != PH_TRANSPORT) begin
        k.status = ST_TRUNC;
      end else if (nh != PROTO_TCP && nh != PROTO_UDP) begin
        k.status = ST_PROTO;
        k.protocol_number = nh;
      end else if (off < (nh == PROTO_TCP ? 20 : 8)) begin
        k.status = ST_TRUNC;
      end else begin
        k.status = ST_OK;
        k.protocol_number = nh;
        k.conn_state = (nh == PROTO_UDP) ? CS_UDP : flag_state(flags, inb);
        if (src_w > dst_w) begin
          k.low_addr = dst_w; k.low_port = dport;
          k.high_addr = src_w; k.high_port = sport;
        end else begin
          k.low_addr = src_w; k.low_port = sport;
          k.high_addr = dst_w; k.high_port = dport;
        end
      end
      key_queue.push_back(k);
      phase = PH_IDLE;
    end
  endtask

  assign pending = key_queue.size();

  always @(posedge clk) begin
    out_word_t e, a;
    if (rst) begin
      phase = PH_IDLE;
      errors <= 0;
      keys_seen <= 0;
      key_queue.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) track_byte(in_mon.data);
      if (out_mon.valid && out_mon.ready) begin
        a = out_mon.data;
        keys_seen <= keys_seen + 1;
        if (key_queue.size() == 0) begin
          if (errors < 10) $display("unexpected result word %h", a);
          errors <= errors + 1;
        end else begin
          e = key_queue.pop_front();
          if (a !== e) begin
            if (errors < 10)
              $display("mismatch: exp st=%0d la=%h ha=%h lp=%h hp=%h pr=%0d cs=%0d d=%0d n=%0d",
                       e.status, e.low_addr, e.high_addr, e.low_port, e.high_port,
                       e.protocol_number, e.conn_state, e.direction_inbound,
                       e.packet_bytes);
            if (errors < 10)
              $display("          got st=%0d la=%h ha=%h lp=%h hp=%h pr=%0d cs=%0d d=%0d n=%0d",
                       a.status, a.low_addr, a.high_addr, a.low_port, a.high_port,
                       a.protocol_number, a.conn_state, a.direction_inbound,
                       a.packet_bytes);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/ip_flow_key_extractor_test.sv =====
// Testbench top for the IP flow key extractor: packet stimulus and verdict.
module ip_flow_key_extractor_test;
  import ipfk_pkg::*;

  logic clk = 0;
  logic rst = 1;
  int   errors, pending, keys_seen;
  int   words_sent = 0;
  int   packets_sent = 0;
  bit   calm = 0;
  bit   hold_off = 0;
  bit   tx_done = 0;
  logic [7:0] pkt[$];

  ipfk_in_if  in_ch();
  ipfk_out_if out_ch();

  ip_flow_key_extractor dut (.clk(clk), .rst(rst), .in(in_ch.sink), .out(out_ch.source));

  ipfk_key_checker chk (
    .clk(clk), .rst(rst), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .errors(errors), .pending(pending), .keys_seen(keys_seen)
  );

  always #5 clk = ~clk;

  // receiver: random stalls, one long hold-off on request
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 0;
    else if (hold_off) out_ch.ready <= 0;
    else out_ch.ready <= calm || ($urandom_range(99) >= 26);
  end

  task automatic send_word(input logic [7:0] b, input logic lst, input logic dir);
    while (!calm && $urandom_range(99) < 26) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.data <= '{data_byte: b, last_byte: lst, arrived_inbound: dir};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_packet(input logic dir);
    for (int i = 0; i < pkt.size(); i++) send_word(pkt[i], i == pkt.size() - 1, dir);
    packets_sent++;
  endtask

  task automatic add_rand(input int n);
    repeat (n) pkt.push_back(8'($urandom_range(255)));
  endtask

  // transport part: tcp 20+, udp 8+, or cut short
  task automatic add_l4(input logic [7:0] proto, input int mode);
    int need;
    need = (proto == PROTO_TCP) ? 20 : 8;
    if (mode == 0) begin
      add_rand($urandom_range(need - 1));
    end else begin
      repeat (4) pkt.push_back(8'($urandom_range(255)));
      repeat (need - 4) pkt.push_back(8'($urandom_range(255)));
      if (proto == PROTO_TCP) begin
        case ($urandom_range(6))
          0: pkt[pkt.size() - 7] = 8'h02;
          1: pkt[pkt.size() - 7] = 8'h12;
          2: pkt[pkt.size() - 7] = 8'h10;
          3: pkt[pkt.size() - 7] = 8'h01;
          4: pkt[pkt.size() - 7] = 8'h04;
          5: pkt[pkt.size() - 7] = 8'h00;
          default: ;
        endcase
      end
      add_rand($urandom_range(3) == 0 ? $urandom_range(20) : 0);
    end
  endtask

  function automatic logic [7:0] pick_proto();
    case ($urandom_range(9))
      0, 1, 2, 3: return PROTO_TCP;
      4, 5, 6: return PROTO_UDP;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic build_v4(input logic [7:0] proto, input int ihl, input int mode,
                          input bit same_addr);
    int hl;
    hl = (ihl < 5) ? 20 : ihl * 4;
    pkt.delete();
    pkt.push_back({4'd4, ihl[3:0]});
    add_rand(hl - 1);
    pkt[9] = proto;
    if (same_addr) for (int i = 0; i < 4; i++) pkt[16 + i] = pkt[12 + i];
    if (ihl < 5 || mode == 2) begin
      if (mode == 2) while (pkt.size() > 1 + $urandom_range(hl - 2)) void'(pkt.pop_back());
      else add_rand($urandom_range(30));
    end else begin
      add_l4(proto, mode);
    end
  endtask

  task automatic build_v6(input logic [7:0] proto, input int n_ext, input int mode);
    logic [7:0] codes[5];
    int base, len, total;
    codes = '{EXT_HOP_OPTS, EXT_ROUTE, EXT_DST_OPTS, EXT_FRAG, EXT_AUTH_HDR};
    pkt.delete();
    pkt.push_back({4'd6, 4'($urandom_range(15))});
    add_rand(39);
    pkt[6] = n_ext ? codes[$urandom_range(4)] : proto;
    for (int e = 0; e < n_ext; e++) begin
      base = pkt.size();
      len = $urandom_range(2);
      if (pkt[base - 0 - 1] === 8'hxx) ;
      pkt.push_back(e == n_ext - 1 ? proto : codes[$urandom_range(4)]);
      pkt.push_back(8'(len));
    end
    // rebuild properly with lengths
    pkt = pkt[0:39];
    begin
      logic [7:0] cur;
      cur = pkt[6];
      for (int e = 0; e < n_ext; e++) begin
        logic [7:0] nx;
        nx = (e == n_ext - 1) ? proto : codes[$urandom_range(4)];
        len = $urandom_range(2);
        if (cur == EXT_FRAG) total = 8;
        else if (cur == EXT_AUTH_HDR) total = (len + 2) * 4;
        else total = (len + 1) * 8;
        pkt.push_back(nx);
        pkt.push_back(8'(len));
        add_rand(total - 2);
        cur = nx;
      end
    end
    if (mode == 2) while (pkt.size() > 1 + $urandom_range(pkt.size() - 2)) void'(pkt.pop_back());
    else add_l4(proto, mode);
  endtask

  task automatic wait_drained();
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    in_ch.valid <= 0;
    in_ch.data <= '0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed
    calm = 1;
    build_v4(PROTO_TCP, 5, 1, 0); pkt[33] = 8'h02; send_packet(0);
    build_v4(PROTO_TCP, 5, 1, 0); pkt[33] = 8'h02; send_packet(1);
    build_v4(PROTO_UDP, 15, 1, 1); send_packet(1);
    build_v4(PROTO_TCP, 3, 1, 0); send_packet(0);
    build_v4(8'd1, 5, 1, 0); send_packet(0);
    build_v4(PROTO_TCP, 5, 2, 0); send_packet(1);
    build_v4(PROTO_TCP, 5, 0, 0); send_packet(0);
    build_v6(PROTO_TCP, 0, 1); send_packet(0);
    build_v6(PROTO_UDP, 3, 1); send_packet(1);
    build_v6(8'd58, 1, 1); send_packet(0);
    build_v6(PROTO_TCP, 2, 2); send_packet(0);
    pkt.delete(); pkt.push_back(8'h00); send_packet(1);
    pkt.delete(); pkt.push_back(8'hFF); add_rand(5); send_packet(0);
    pkt.delete(); pkt.push_back(8'h45); send_packet(1);
    build_v4(PROTO_UDP, 5, 1, 0); add_rand(40); send_packet(1);
    wait_drained();

    // long receiver stall while bytes keep coming
    calm = 0;
    hold_off = 1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      repeat (8) begin
        build_v4(PROTO_UDP, 5, 1, 0); send_packet(1'($urandom_range(1)));
      end
    join
    wait_drained();

    while (words_sent < 1100) begin
      case ($urandom_range(9))
        0, 1, 2, 3: build_v4(pick_proto(), $urandom_range(9) ? 5 + $urandom_range(2)
                                        : $urandom_range(15), $urandom_range(9) ? 1 : $urandom_range(2),
                             $urandom_range(15) == 0);
        4, 5, 6, 7: build_v6(pick_proto(), $urandom_range(3),
                             $urandom_range(9) ? 1 : $urandom_range(2));
        default: begin
          pkt.delete();
          add_rand(1 + $urandom_range(40));
        end
      endcase
      send_packet(1'($urandom_range(1)));
      if (packets_sent % 40 == 0) calm = ~calm;
    end
    in_ch.valid <= 0;
    tx_done = 1;
  end

  initial begin
    wait (tx_done);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("sent %0d packets in %0d bytes; %0d flow keys checked, %0d errors",
             packets_sent, words_sent, keys_seen, errors);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("FAIL");
    $finish;
  end
endmodule

// ===== ip_flow_key_extractor.f =====
rtl/ipfk_pkg.sv
rtl/ipfk_if.sv
rtl/ipfk_parser.sv
rtl/ipfk_fifo.sv
rtl/ipfk_keygen.sv
rtl/ip_flow_key_extractor.sv
tb/ipfk_key_checker.sv
tb/ip_flow_key_extractor_test.sv
